[rtl/mm4_pkg.sv]
// ----------------------------------------------------------------------------
// mm4_pkg: shared types and constants for the 4x4 matrix multiply unit
// Beat formats for the row and result channels, the item kind codes, and
// the fixed-point constants of the signed Q16.16 datapath.
// ----------------------------------------------------------------------------
package mm4_pkg;

	// Matrix dimension and fixed-point format.
	localparam int DIM       = 4;
	localparam int ELEM_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int PROD_W    = 2 * ELEM_W;
	localparam int SUM_W     = PROD_W + 2;

	localparam logic signed [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam logic signed [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [1:0]               row_idx_t;

	// Item kinds carried on the row channel.
	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_MUL  = 1'b1
	} kind_t;

	// One beat on the row channel.
	typedef struct packed {
		kind_t    kind;
		row_idx_t row_index;
		elem_t    elem_x;
		elem_t    elem_y;
		elem_t    elem_z;
		elem_t    elem_w;
	} row_beat_t;

	// One beat on the result channel.
	typedef struct packed {
		row_idx_t result_row;
		elem_t    out_x;
		elem_t    out_y;
		elem_t    out_z;
		elem_t    out_w;
	} res_beat_t;

endpackage

[rtl/mm4_sat_sum.sv]
// ----------------------------------------------------------------------------
// mm4_sat_sum: exact sum of four products, floor shift and saturation
// Adds four full-width Q32.32 products without loss, drops the low fraction
// bits with an arithmetic shift and clamps the result to the signed 32-bit
// range.
// ----------------------------------------------------------------------------
module mm4_sat_sum (
	input  mm4_pkg::prod_t prod [mm4_pkg::DIM],
	output mm4_pkg::elem_t sum_sat
);
	import mm4_pkg::*;

	localparam int HI_W = SUM_W - FRAC_W - ELEM_W + 1;

	logic signed [SUM_W-1:0] sum_full;
	logic [HI_W-1:0]         sum_hi;

	// Exact sum of the sign-extended products.
	always_comb begin
		sum_full = '0;
		for (int k = 0; k < DIM; k++) begin
			sum_full = sum_full + SUM_W'(prod[k]);
		end
	end

	// The bits above the kept result plus its sign bit must all agree,
	// otherwise the shifted sum lies outside the 32-bit range.
	assign sum_hi = sum_full[SUM_W-1 -: HI_W];

	always_comb begin
		if (sum_hi == '0 || sum_hi == '1) begin
			sum_sat = sum_full[FRAC_W +: ELEM_W];
		end else if (sum_full[SUM_W-1]) begin
			sum_sat = SAT_MIN;
		end else begin
			sum_sat = SAT_MAX;
		end
	end

endmodule

[rtl/matrix_multiply_4x4_unit.sv]
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_unit: streaming 4x4 matrix multiply, signed Q16.16
// Holds the right-hand matrix and multiplies left-hand rows against it.
// ----------------------------------------------------------------------------
// Usage:
//   Row channel (row_valid, row_stall, row_data): a load beat writes the four
//   elements into stored row row_index at the edge it is accepted and gives
//   no result. A multiply beat gives one result beat with the product row.
//   Result channel (res_valid, res_stall, res_data): result_row echoes the
//   row number, out_x..out_w are the saturated Q16.16 products.
//   A multiply accepted on the row channel passes the input register, the
//   product register and the result register before it shows as a result.
//   Throughput: one beat per cycle of either kind while res_stall is low.
//   The figure is set by the product stage, with sixteen 32x32 multipliers
//   in parallel, one per stored element, and by the four-way result sum.
//   A load may be followed at once by a multiply that uses the new row.
//   Reset clears the pipeline valid bits only; the stored matrix is undefined
//   until each row has been loaded.
//   When the receiver stalls, the pipeline fills up stage by stage and the
//   row channel stalls once the input register cannot move on; no beat is
//   lost or repeated.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               row_valid,
	output logic               row_stall,
	input  mm4_pkg::row_beat_t row_data,
	output logic               res_valid,
	input  logic               res_stall,
	output mm4_pkg::res_beat_t res_data
);
	import mm4_pkg::*;

	// Stored right-hand matrix, [row][column].
	elem_t    store_q [DIM][DIM];

	// Stage 1: registered left row.
	logic     v1_q;
	row_idx_t row_s1;
	elem_t    elem_s1 [DIM];

	// Stage 2: registered products, [k][column].
	logic     v2_q;
	row_idx_t row_s2;
	prod_t    prod_s2 [DIM][DIM];

	// Stage 3: result register.
	logic     v3_q;

	logic     en1, en2, en3;
	logic     row_acc;
	elem_t    col_sum [DIM];
	prod_t    col_prod [DIM][DIM];

	// Stage enables: a stage loads when it is empty or its content moves on.
	assign en3       = !v3_q || !res_stall;
	assign en2       = !v2_q || en3;
	assign en1       = !v1_q || en2;
	assign row_stall = !en1;
	assign row_acc   = row_valid && en1;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= row_valid && (row_data.kind == KIND_MUL);
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en3) begin
				v3_q <= v2_q;
			end
		end
	end

	// Matrix store: a load beat writes its row at acceptance.
	always_ff @(posedge clk) begin
		if (row_acc && row_data.kind == KIND_LOAD) begin
			store_q[row_data.row_index][0] <= row_data.elem_x;
			store_q[row_data.row_index][1] <= row_data.elem_y;
			store_q[row_data.row_index][2] <= row_data.elem_z;
			store_q[row_data.row_index][3] <= row_data.elem_w;
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (en1) begin
			row_s1     <= row_data.row_index;
			elem_s1[0] <= row_data.elem_x;
			elem_s1[1] <= row_data.elem_y;
			elem_s1[2] <= row_data.elem_z;
			elem_s1[3] <= row_data.elem_w;
		end
	end

	// Product stage: every left element times every stored element of its row.
	always_ff @(posedge clk) begin
		if (en2) begin
			row_s2 <= row_s1;
			for (int k = 0; k < DIM; k++) begin
				for (int j = 0; j < DIM; j++) begin
					prod_s2[k][j] <= PROD_W'(elem_s1[k]) * PROD_W'(store_q[k][j]);
				end
			end
		end
	end

	// Regroup the products by column for the summing units.
	always_comb begin
		for (int j = 0; j < DIM; j++) begin
			for (int k = 0; k < DIM; k++) begin
				col_prod[j][k] = prod_s2[k][j];
			end
		end
	end

	// One summing unit per result column.
	for (genvar j = 0; j < DIM; j++) begin : g_col
		mm4_sat_sum u_sum (
			.prod    (col_prod[j]),
			.sum_sat (col_sum[j])
		);
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (en3) begin
			res_data.result_row <= row_s2;
			res_data.out_x      <= col_sum[0];
			res_data.out_y      <= col_sum[1];
			res_data.out_z      <= col_sum[2];
			res_data.out_w      <= col_sum[3];
		end
	end

	assign res_valid = v3_q;

	// The row channel only stalls while a multiply waits in the input register.
	a_stall_needs_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		row_stall |-> v1_q)
		else $error("row channel stalled with an empty input register");

	// An accepted multiply occupies the input register in the next cycle.
	a_mul_enters : assert property (@(posedge clk) disable iff (!arst_n)
		(row_acc && row_data.kind == KIND_MUL) |=> v1_q)
		else $error("accepted multiply beat was dropped");

	// An accepted load is visible in the store in the next cycle.
	a_load_written : assert property (@(posedge clk) disable iff (!arst_n)
		(row_acc && row_data.kind == KIND_LOAD) |=>
		(store_q[$past(row_data.row_index)][0] == $past(row_data.elem_x) &&
		 store_q[$past(row_data.row_index)][3] == $past(row_data.elem_w)))
		else $error("load beat did not reach the matrix store");

	// A result taken from the product stage carries that stage's row number.
	a_row_follows : assert property (@(posedge clk) disable iff (!arst_n)
		(v2_q && en3) |=> (res_valid && res_data.result_row == $past(row_s2)))
		else $error("result row number does not follow the pipeline");

	// A held result stays valid until the receiver takes it.
	a_res_held : assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> res_valid)
		else $error("stalled result beat disappeared");

endmodule

[bench/matrix_multiply_4x4_unit_test.sv]
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_unit_test: self-checking bench for the 4x4 multiplier
// Loads right-hand rows and streams left-hand rows through the unit. Each
// expected product row is computed in the bench from its own copy of the
// stored matrix and is compared field by field with the result beats in order.
// Both channels stall and idle at random, and one long hold on the result side
// fills the pipeline.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4_unit_test;

	import mm4_pkg::*;

	localparam int   CYCLE_LIMIT  = 200000;
	localparam int   IDLE_PCT     = 14;
	localparam int   HOLD_CYCLES  = 80;
	localparam int   DRAIN_CYCLES = 10;
	localparam int   RANDOM_ROWS  = 830;
	localparam elem_t Q_ONE       = 32'sh0001_0000;

	localparam logic signed [SUM_W-1:0] SUM_HI = SAT_MAX;
	localparam logic signed [SUM_W-1:0] SUM_LO = SAT_MIN;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      row_valid = 1'b0;
	logic      row_stall;
	row_beat_t row_data  = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_beat_t res_data;

	row_beat_t pending_rows[$];
	res_beat_t expected_products[$];
	elem_t     right_rows[DIM*DIM];

	logic      row_fire      = 1'b0;
	int        rows_accepted = 0;
	int        results_seen  = 0;
	int        mismatches    = 0;
	int        cycle_count   = 0;
	int        hold_left     = 0;
	logic      held_once     = 1'b0;
	logic      steady;

	matrix_multiply_4x4_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_valid (row_valid),
		.row_stall (row_stall),
		.row_data  (row_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	// Clock and a single reset at the start of the run.
	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Neither side idles during this window of the stream.
	assign steady = (rows_accepted >= 300) && (rows_accepted < 450);

	// Print one mismatch line and count it.
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("[%0d] %s: got %h, want %h", cycle_count, what, got, want);
	endtask

	// Product row of a left-hand row against the stored right-hand matrix.
	// Exact four-term sum, arithmetic shift by the fraction width, saturation.
	function automatic res_beat_t multiply_row(row_beat_t beat);
		elem_t                   left[DIM];
		elem_t                   col[DIM];
		logic signed [SUM_W-1:0] acc;
		logic signed [SUM_W-1:0] scaled;
		res_beat_t               prod;
		left = '{beat.elem_x, beat.elem_y, beat.elem_z, beat.elem_w};
		for (int j = 0; j < DIM; j++) begin
			acc = '0;
			for (int k = 0; k < DIM; k++) begin
				acc = acc + (prod_t'(left[k]) * prod_t'(right_rows[k*DIM + j]));
			end
			scaled = acc >>> FRAC_W;
			if (scaled > SUM_HI) begin
				col[j] = SAT_MAX;
			end else if (scaled < SUM_LO) begin
				col[j] = SAT_MIN;
			end else begin
				col[j] = scaled[ELEM_W-1:0];
			end
		end
		prod.result_row = beat.row_index;
		prod.out_x      = col[0];
		prod.out_y      = col[1];
		prod.out_z      = col[2];
		prod.out_w      = col[3];
		return prod;
	endfunction

	function automatic row_beat_t make_row(kind_t k, row_idx_t r,
	                                       elem_t x, elem_t y, elem_t z, elem_t w);
		row_beat_t beat;
		beat.kind      = k;
		beat.row_index = r;
		beat.elem_x    = x;
		beat.elem_y    = y;
		beat.elem_z    = z;
		beat.elem_w    = w;
		return beat;
	endfunction

	// Element mix: extremes, zero, full-range noise, and small Q16.16 values.
	function automatic elem_t pick_elem();
		int v;
		case ($urandom_range(9))
			0: return SAT_MAX;
			1: return SAT_MIN;
			2: return '0;
			3, 4, 5: return elem_t'($urandom());
			default: begin
				v = int'($urandom_range(0, 524287)) - 262144;
				return elem_t'(v);
			end
		endcase
	endfunction

	// Result side: check each result beat, then predict from each row beat.
	always @(posedge clk) begin
		res_beat_t want;
		if (arst_n && res_valid && !res_stall) begin
			results_seen <= results_seen + 1;
			if (expected_products.size() == 0) begin
				report_mismatch("unexpected result", res_data.out_x, '0);
			end else begin
				want = expected_products.pop_front();
				if (res_data.result_row !== want.result_row)
					report_mismatch("result_row", res_data.result_row, want.result_row);
				if (res_data.out_x !== want.out_x)
					report_mismatch("out_x", res_data.out_x, want.out_x);
				if (res_data.out_y !== want.out_y)
					report_mismatch("out_y", res_data.out_y, want.out_y);
				if (res_data.out_z !== want.out_z)
					report_mismatch("out_z", res_data.out_z, want.out_z);
				if (res_data.out_w !== want.out_w)
					report_mismatch("out_w", res_data.out_w, want.out_w);
			end
		end
		if (arst_n && row_valid && !row_stall) begin
			rows_accepted <= rows_accepted + 1;
			if (row_data.kind == KIND_LOAD) begin
				right_rows[row_data.row_index*DIM + 0] = row_data.elem_x;
				right_rows[row_data.row_index*DIM + 1] = row_data.elem_y;
				right_rows[row_data.row_index*DIM + 2] = row_data.elem_z;
				right_rows[row_data.row_index*DIM + 3] = row_data.elem_w;
			end else begin
				expected_products.push_back(multiply_row(row_data));
			end
		end
	end

	// Remember whether the row beat was taken at the last rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_fire <= 1'b0;
		end else begin
			row_fire <= row_valid && !row_stall;
		end
	end

	// Row driver: a new beat or an idle cycle once the current one is gone.
	always @(negedge clk) begin
		if (!arst_n) begin
			row_valid <= 1'b0;
		end else if (!row_valid || row_fire) begin
			if (pending_rows.size() != 0 &&
			    (steady || $urandom_range(99) >= IDLE_PCT)) begin
				row_valid <= 1'b1;
				row_data  <= pending_rows.pop_front();
			end else begin
				row_valid <= 1'b0;
			end
		end
	end

	// Long hold: one stretch of stall cycles, counted down once it starts.
	always @(negedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!held_once && results_seen >= 150) begin
			hold_left <= HOLD_CYCLES;
			held_once <= 1'b1;
		end
	end

	// Result receiver: random stalls, and a steady stall during the long hold.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else if (hold_left != 0) begin
			res_stall <= 1'b1;
		end else begin
			res_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Stimulus and end of run.
	initial begin
		row_beat_t beat;

		// Identity matrix: each product equals its left row, extremes included.
		for (int r = 0; r < DIM; r++) begin
			pending_rows.push_back(make_row(KIND_LOAD, row_idx_t'(r),
				(r == 0) ? Q_ONE : elem_t'(0), (r == 1) ? Q_ONE : elem_t'(0),
				(r == 2) ? Q_ONE : elem_t'(0), (r == 3) ? Q_ONE : elem_t'(0)));
		end
		pending_rows.push_back(make_row(KIND_MUL, 2'd0, SAT_MAX, SAT_MIN, -1, 1));
		pending_rows.push_back(make_row(KIND_MUL, 2'd1, SAT_MIN, SAT_MAX, 1, -1));
		pending_rows.push_back(make_row(KIND_MUL, 2'd2, 0, 0, 0, 0));
		pending_rows.push_back(make_row(KIND_MUL, 2'd3, -1, -1, -1, -1));

		// Extreme matrix: overflow in both directions and floor rounding.
		pending_rows.push_back(make_row(KIND_LOAD, 2'd0, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
		pending_rows.push_back(make_row(KIND_LOAD, 2'd1, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
		pending_rows.push_back(make_row(KIND_LOAD, 2'd2, -1, -1, -1, -1));
		pending_rows.push_back(make_row(KIND_LOAD, 2'd3, Q_ONE, -Q_ONE, 1, 0));
		pending_rows.push_back(make_row(KIND_MUL, 2'd0, SAT_MAX, 0, 0, 0));
		pending_rows.push_back(make_row(KIND_MUL, 2'd1, SAT_MIN, 0, 0, 0));
		pending_rows.push_back(make_row(KIND_MUL, 2'd2, 0, SAT_MIN, 0, 0));
		pending_rows.push_back(make_row(KIND_MUL, 2'd3, -1, 0, 0, 0));
		pending_rows.push_back(make_row(KIND_MUL, 2'd0, 1, 1, 1, 1));
		pending_rows.push_back(make_row(KIND_MUL, 2'd1, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
		pending_rows.push_back(make_row(KIND_MUL, 2'd2, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
		// A load followed at once by a multiply that uses the new row.
		pending_rows.push_back(make_row(KIND_LOAD, 2'd3, SAT_MIN, SAT_MAX, 0, -1));
		pending_rows.push_back(make_row(KIND_MUL, 2'd3, 0, 0, 0, SAT_MIN));

		// Random rows: mostly multiplies, with reloads scattered through.
		for (int i = 0; i < RANDOM_ROWS; i++) begin
			beat.kind      = ($urandom_range(99) < 30) ? KIND_LOAD : KIND_MUL;
			beat.row_index = row_idx_t'($urandom_range(3));
			beat.elem_x    = pick_elem();
			beat.elem_y    = pick_elem();
			beat.elem_z    = pick_elem();
			beat.elem_w    = pick_elem();
			pending_rows.push_back(beat);
		end

		while (pending_rows.size() != 0 || row_valid) @(posedge clk);
		while (expected_products.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Timeout on a cycle count far beyond the slowest correct run.
	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("Mismatches found");
		$finish;
	end

endmodule

[filelist.f]
rtl/mm4_pkg.sv
rtl/mm4_sat_sum.sv
rtl/matrix_multiply_4x4_unit.sv
bench/matrix_multiply_4x4_unit_test.sv
